FILE: hdl/mcps_pkg.sv
// Package for the momentum conserving pair sampler.
// Holds item kinds, item types, sequencer states and the shared geometry constants.
package mcps_pkg;
  localparam int unsigned MaxOrbitals = 512;
  localparam int unsigned MaxCutoff = 4;
  localparam int unsigned FractionBits = 16;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_PARALLEL = 2'd1,
    KIND_ANTIPARALLEL = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_SUM,
    ST_WALK,
    ST_SELECT,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e             kind_i;
    logic [8:0]        orbital_slot_i;
    logic signed [3:0] mom_x_i;
    logic signed [3:0] mom_y_i;
    logic signed [3:0] mom_z_i;
    logic [9:0]        first_spin_orbital_i;
    logic [9:0]        second_spin_orbital_i;
    logic              spin_bit_i;
    logic [15:0]       choice_fraction_i;
    logic              spin_order_i;
  } req_t;

  typedef struct packed {
    logic [9:0] out_first_o;
    logic [9:0] out_second_o;
    logic [9:0] inverse_probability_o;
    logic       empty_space_o;
  } res_t;

  localparam logic [1:0] RegCutoff = 2'd0;
  localparam logic [1:0] RegOrbitalCount = 2'd1;
endpackage

FILE: hdl/mcps_stream_if.sv
// Valid/ready channel interface carrying one item of type item_t.
// Depends on nothing but the payload type given as a parameter.
interface mcps_stream_if #(
  parameter type item_t = logic
);
  logic valid;
  logic ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mcps_ram.sv
// Generic single-port write, single-port registered-read RAM.
// Used for the momentum table and the momentum map.
module mcps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/momentum_conserving_pair_sampler.sv
// Momentum conserving pair sampler: load orbital momenta, sample pairs.
// Depends on mcps_pkg, mcps_stream_if and mcps_ram.
//
// Input items arrive on in_if and results leave on out_if, both valid/ready.
// After reset the block clears the momentum map and is not ready
// meanwhile; cutoff is 4 and orbital_count is 1.
// A load item writes the momentum table and, when inside the cutoff,
// the momentum map, and gives no result.
// A sample item reads its two orbitals in the FETCH_A and FETCH_B states,
// then walks the orbital table through one table port and one map port:
// once to count members and, if there are any, once more up to the
// selected member. When orbital_count is zero no walk is made.
// The block takes one item at a time and is not ready while it works.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its output state, and the block is ready again the
// cycle after the result is taken. Configuration is written through the
// APB port while the block is idle, a user rule the block does not enforce.
module momentum_conserving_pair_sampler #(
  parameter int unsigned MaxOrbitals = mcps_pkg::MaxOrbitals,
  parameter int unsigned MaxCutoff = mcps_pkg::MaxCutoff,
  parameter int unsigned FractionBits = mcps_pkg::FractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mcps_stream_if.sink   in_if,
  mcps_stream_if.source out_if
);
  localparam int unsigned SlotW = $clog2(MaxOrbitals);
  localparam int unsigned Side = 2 * MaxCutoff + 1;
  localparam int unsigned MapDepth = Side * Side * Side;
  localparam int unsigned MapW = $clog2(MapDepth);
  localparam int unsigned CntW = $clog2(MaxOrbitals + 1);
  localparam int unsigned CW = $clog2(MaxCutoff + 1);

  logic [2:0] cutoff_q;
  logic [9:0] count_reg_q;
  logic [CW-1:0] ceff;
  logic [CntW-1:0] n_eff;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == mcps_pkg::RegOrbitalCount[0]) begin
      prdata = {22'd0, count_reg_q};
    end else begin
      prdata = {29'd0, cutoff_q};
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 3'd4;
      count_reg_q <= 10'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mcps_pkg::RegCutoff[0]) begin
        cutoff_q <= pwdata[2:0];
      end else begin
        count_reg_q <= pwdata[9:0];
      end
    end
  end
  assign ceff = (32'(cutoff_q) > MaxCutoff) ? CW'(MaxCutoff) : CW'(cutoff_q);
  assign n_eff = (32'(count_reg_q) > MaxOrbitals) ? CntW'(MaxOrbitals) : CntW'(count_reg_q);

  mcps_pkg::state_e state_q, state_d;
  mcps_pkg::kind_e kind_q;
  logic [SlotW-1:0] a2_q;
  logic spin_q, order_q;
  logic [FractionBits-1:0] frac_q;
  logic signed [5:0] kt_q [3];
  logic signed [3:0] ka_q [3];
  logic [CntW-1:0] idx_q, count_q, seen_q, sel_q;
  logic pass_q, phase_q, same_q, probe_ok_q;
  logic [9:0] of_q, os_q, ip_q;
  logic empty_q, ovalid_q;
  logic [MapW-1:0] clr_q;

  logic clearing;
  logic tab_we;
  logic [SlotW-1:0] tab_waddr, tab_raddr;
  logic [11:0] tab_rdata;
  logic map_we;
  logic [MapW-1:0] map_waddr, map_raddr;
  logic [SlotW:0] map_wdata, map_rdata;

  mcps_ram #(.Width(12), .Depth(MaxOrbitals)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr),
    .wdata_i({in_if.data.mom_z_i, in_if.data.mom_y_i, in_if.data.mom_x_i}),
    .raddr_i(tab_raddr), .rdata_o(tab_rdata));
  mcps_ram #(.Width(SlotW + 1), .Depth(MapDepth)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata));

  // Map address of a signed 3D momentum; valid flag when inside the cutoff.
  function automatic logic [MapW:0] map_index(input logic signed [6:0] x,
      input logic signed [6:0] y, input logic signed [6:0] z, input logic [CW-1:0] c);
    logic signed [7:0] cs;
    logic [MapW+7:0] s, a;
    logic ok;
    begin
      cs = 8'(c);
      ok = (8'(x) >= -cs) && (8'(x) <= cs) && (8'(y) >= -cs) && (8'(y) <= cs)
        && (8'(z) >= -cs) && (8'(z) <= cs);
      s = (MapW + 8)'(2 * c + 1);
      a = (MapW + 8)'(8'(x) + cs) + s * ((MapW + 8)'(8'(y) + cs)
        + s * (MapW + 8)'(8'(z) + cs));
      map_index = {ok, MapW'(a)};
    end
  endfunction

  logic signed [3:0] rx, ry, rz;
  logic signed [6:0] dx, dy, dz;
  logic [MapW:0] probe, load_idx;
  logic [CntW+FractionBits-1:0] prod;
  logic start_sample;

  assign rx = tab_rdata[3:0];
  assign ry = tab_rdata[7:4];
  assign rz = tab_rdata[11:8];
  assign dx = 7'(kt_q[0]) - 7'(rx);
  assign dy = 7'(kt_q[1]) - 7'(ry);
  assign dz = 7'(kt_q[2]) - 7'(rz);
  assign probe = map_index(dx, dy, dz, ceff);
  assign load_idx = map_index(7'(in_if.data.mom_x_i), 7'(in_if.data.mom_y_i),
    7'(in_if.data.mom_z_i), ceff);
  assign prod = (CntW + FractionBits)'(frac_q) * (CntW + FractionBits)'(count_q);

  logic accept, is_member;
  assign clearing = (state_q == mcps_pkg::ST_CLEAR);
  assign in_if.ready = (state_q == mcps_pkg::ST_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign start_sample = accept && (in_if.data.kind_i == mcps_pkg::KIND_PARALLEL
    || in_if.data.kind_i == mcps_pkg::KIND_ANTIPARALLEL);
  assign tab_we = accept && in_if.data.kind_i == mcps_pkg::KIND_LOAD;
  assign tab_waddr = in_if.data.orbital_slot_i[SlotW-1:0];
  assign map_we = clearing || (tab_we && load_idx[MapW]);
  assign map_waddr = clearing ? clr_q : load_idx[MapW-1:0];
  assign map_wdata = clearing ? '0 : {1'b1, in_if.data.orbital_slot_i[SlotW-1:0]};
  assign is_member = probe_ok_q && map_rdata[SlotW] &&
    !(kind_q == mcps_pkg::KIND_PARALLEL && same_q);

  always_comb begin
    tab_raddr = idx_q[SlotW-1:0];
    case (state_q)
      mcps_pkg::ST_IDLE: tab_raddr = in_if.data.first_spin_orbital_i[SlotW:1];
      mcps_pkg::ST_FETCH_A: tab_raddr = a2_q;
      mcps_pkg::ST_SUM: tab_raddr = '0;
      mcps_pkg::ST_SELECT: tab_raddr = '0;
      mcps_pkg::ST_WALK: tab_raddr = phase_q ? SlotW'(idx_q + CntW'(1)) : idx_q[SlotW-1:0];
      default: tab_raddr = idx_q[SlotW-1:0];
    endcase
  end
  assign map_raddr = probe[MapW] ? probe[MapW-1:0] : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mcps_pkg::ST_CLEAR: if (clr_q == MapW'(MapDepth - 1)) state_d = mcps_pkg::ST_IDLE;
      mcps_pkg::ST_IDLE: if (start_sample) state_d = mcps_pkg::ST_FETCH_A;
      mcps_pkg::ST_FETCH_A: state_d = mcps_pkg::ST_FETCH_B;
      mcps_pkg::ST_FETCH_B: state_d = mcps_pkg::ST_SUM;
      mcps_pkg::ST_SUM: state_d = (n_eff == '0) ? mcps_pkg::ST_OUT : mcps_pkg::ST_WALK;
      mcps_pkg::ST_WALK: if (phase_q && idx_q == n_eff - CntW'(1)) begin
        state_d = pass_q ? mcps_pkg::ST_OUT : mcps_pkg::ST_SELECT;
      end else if (phase_q && pass_q && is_member && seen_q == sel_q) begin
        state_d = mcps_pkg::ST_OUT;
      end
      mcps_pkg::ST_SELECT: state_d = (count_q == '0) ? mcps_pkg::ST_OUT : mcps_pkg::ST_WALK;
      mcps_pkg::ST_OUT: if (out_if.ready || !ovalid_q) state_d = ovalid_q ?
        mcps_pkg::ST_IDLE : mcps_pkg::ST_OUT;
      default: state_d = mcps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcps_pkg::ST_CLEAR;
      clr_q <= '0;
      ovalid_q <= 1'b0;
      phase_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mcps_pkg::ST_CLEAR: clr_q <= clr_q + MapW'(1);
        mcps_pkg::ST_SUM: begin
          phase_q <= 1'b0;
          pass_q <= 1'b0;
          ovalid_q <= (n_eff == '0);
        end
        mcps_pkg::ST_WALK: begin
          phase_q <= !phase_q;
          if (state_d == mcps_pkg::ST_OUT) ovalid_q <= 1'b1;
        end
        mcps_pkg::ST_SELECT: begin
          pass_q <= 1'b1;
          phase_q <= 1'b0;
          ovalid_q <= (count_q == '0);
        end
        mcps_pkg::ST_OUT: if (out_if.ready) ovalid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mcps_pkg::ST_IDLE: if (start_sample) begin
        kind_q <= in_if.data.kind_i;
        a2_q <= in_if.data.second_spin_orbital_i[SlotW:1];
        spin_q <= in_if.data.spin_bit_i;
        order_q <= in_if.data.spin_order_i;
        frac_q <= in_if.data.choice_fraction_i[FractionBits-1:0];
      end
      mcps_pkg::ST_FETCH_A: begin
        ka_q[0] <= rx;
        ka_q[1] <= ry;
        ka_q[2] <= rz;
      end
      mcps_pkg::ST_FETCH_B: begin
        kt_q[0] <= 6'(ka_q[0]) + 6'(rx);
        kt_q[1] <= 6'(ka_q[1]) + 6'(ry);
        kt_q[2] <= 6'(ka_q[2]) + 6'(rz);
      end
      mcps_pkg::ST_SUM: begin
        idx_q <= '0;
        count_q <= '0;
        seen_q <= '0;
        empty_q <= 1'b1;
        of_q <= '0;
        os_q <= '0;
        ip_q <= '0;
      end
      mcps_pkg::ST_WALK: begin
        if (!phase_q) begin
          probe_ok_q <= probe[MapW];
          same_q <= (dx == 7'(rx)) && (dy == 7'(ry)) && (dz == 7'(rz));
        end else begin
          idx_q <= idx_q + CntW'(1);
          if (is_member && !pass_q) count_q <= count_q + CntW'(1);
          if (is_member && pass_q) begin
            seen_q <= seen_q + CntW'(1);
            if (seen_q == sel_q) begin
              empty_q <= 1'b0;
              of_q <= 10'({idx_q[SlotW-1:0], (kind_q == mcps_pkg::KIND_PARALLEL)
                ? spin_q : !order_q});
              os_q <= 10'({map_rdata[SlotW-1:0], (kind_q == mcps_pkg::KIND_PARALLEL)
                ? spin_q : order_q});
              ip_q <= (kind_q == mcps_pkg::KIND_PARALLEL) ?
                10'(count_q >> 1) : 10'(count_q);
            end
          end
        end
      end
      mcps_pkg::ST_SELECT: begin
        idx_q <= '0;
        sel_q <= CntW'(prod >> FractionBits);
      end
      default: ;
    endcase
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data.out_first_o = of_q;
  assign out_if.data.out_second_o = os_q;
  assign out_if.data.inverse_probability_o = ip_q;
  assign out_if.data.empty_space_o = empty_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> state_q == mcps_pkg::ST_OUT) else $error("result outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.empty_space_o |-> out_if.data.inverse_probability_o == '0)
    else $error("empty result with nonzero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcps_pkg::ST_WALK |-> idx_q < n_eff) else $error("walk index overrun");
endmodule
